### hdl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants for the cube-sphere tessellator.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int MAX_VERTS_PER_EDGE = 256;
  localparam int FACE_LAST  = 5;
  localparam int IDX_W      = 19;
  localparam int POS_W      = 16;
  localparam int MAG_W      = 15;
  localparam int S_W        = 18;
  localparam int SQ_W       = 17;
  localparam int T_W        = 47;
  localparam int E_W        = 52;
  localparam int P_W        = 36;
  localparam int ONE_SHIFT  = 30;

  typedef enum logic {
    OP_VERTEX = 1'b0,
    OP_QUAD   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    BEAT_LT  = 3'd0,
    BEAT_LB  = 3'd1,
    BEAT_RT  = 3'd2,
    BEAT_RB  = 3'd3,
    BEAT_RT2 = 3'd4,
    BEAT_LB2 = 3'd5
  } beat_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic [2:0]       face;
    logic [8:0]       n;
    logic [IDX_W-1:0] lt;
    logic             neg_a;
    logic             neg_b;
    logic [S_W-1:0]   s;
  } side_t;

  typedef struct packed {
    logic [MAG_W-1:0]      m;
    logic signed [E_W-1:0] e;
    logic signed [P_W-1:0] p;
    logic [T_W-1:0]        t;
  } comp_t;

  typedef struct packed {
    side_t       side;
    comp_t [2:0] c;
  } norm_t;

endpackage

### hdl/cst_front.sv
// ----------------------------------------------------------------------------
// cst_front
// Clamping, squares, vertex index and search set-up in three stages.
// ----------------------------------------------------------------------------
module cst_front #(
  parameter int MAX_VERTS_PER_EDGE = cst_pkg::MAX_VERTS_PER_EDGE
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [7:0]          detail,
  input  logic                in_valid,
  input  logic                in_op,
  input  logic [2:0]          in_face,
  input  logic [7:0]          in_row,
  input  logic [7:0]          in_column,
  output cst_pkg::norm_t      norm_o
);

  localparam logic [10:0] QCAP = 11'(MAX_VERTS_PER_EDGE - 1);

  // stage 1
  logic                    v1_r;
  cst_pkg::op_t            op1_r;
  logic [2:0]              face1_r;
  logic [8:0]              q1_r, row1_r, col1_r;
  logic signed [10:0]      a1_r, b1_r;
  // stage 2
  logic                    v2_r;
  cst_pkg::op_t            op2_r;
  logic [2:0]              face2_r;
  logic [8:0]              n2_r, col2_r;
  logic [17:0]             nn2_r, rn2_r;
  logic [cst_pkg::SQ_W-1:0] q2_r, a2_r, b2_r;
  logic                    na2_r, nb2_r;
  // stage 3
  cst_pkg::norm_t          n3_r;

  logic [10:0]             q_ext;
  logic [8:0]              q, lim, row_c, col_c;
  logic [2:0]              face_c;
  logic [17:0]             n1_w;
  logic [cst_pkg::S_W-1:0] s_sum;
  logic [21:0]             lt_full;
  cst_pkg::norm_t          n3_nxt;

  always_comb begin
    q_ext  = {3'b000, detail} + 11'd1;
    q      = (q_ext > QCAP) ? QCAP[8:0] : q_ext[8:0];
    lim    = in_op ? (q - 9'd1) : q;
    row_c  = ({1'b0, in_row} > lim) ? lim : {1'b0, in_row};
    col_c  = ({1'b0, in_column} > lim) ? lim : {1'b0, in_column};
    face_c = (in_face > 3'(cst_pkg::FACE_LAST)) ? 3'(cst_pkg::FACE_LAST) : in_face;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      op1_r   <= cst_pkg::op_t'(in_op);
      face1_r <= face_c;
      q1_r    <= q;
      row1_r  <= row_c;
      col1_r  <= col_c;
      a1_r    <= $signed({1'b0, col_c, 1'b0}) - $signed({2'b00, q});
      b1_r    <= $signed({1'b0, row_c, 1'b0}) - $signed({2'b00, q});
    end
  end

  assign n1_w = 18'(q1_r) + 18'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      op2_r   <= op1_r;
      face2_r <= face1_r;
      n2_r    <= q1_r + 9'd1;
      col2_r  <= col1_r;
      nn2_r   <= n1_w * n1_w;
      rn2_r   <= 18'(row1_r) * n1_w;
      q2_r    <= cst_pkg::SQ_W'(18'(q1_r) * 18'(q1_r));
      a2_r    <= cst_pkg::SQ_W'(22'(a1_r) * 22'(a1_r));
      b2_r    <= cst_pkg::SQ_W'(22'(b1_r) * 22'(b1_r));
      na2_r   <= a1_r[10];
      nb2_r   <= b1_r[10];
    end
  end

  always_comb begin
    s_sum   = cst_pkg::S_W'(q2_r) + cst_pkg::S_W'(a2_r) + cst_pkg::S_W'(b2_r);
    lt_full = 22'(face2_r) * 22'(nn2_r) + 22'(rn2_r) + 22'(col2_r);
    n3_nxt.side.valid = v2_r;
    n3_nxt.side.op    = op2_r;
    n3_nxt.side.face  = face2_r;
    n3_nxt.side.n     = n2_r;
    n3_nxt.side.lt    = lt_full[cst_pkg::IDX_W-1:0];
    n3_nxt.side.neg_a = na2_r;
    n3_nxt.side.neg_b = nb2_r;
    n3_nxt.side.s     = s_sum;
    n3_nxt.c[0].t = cst_pkg::T_W'(q2_r) << cst_pkg::ONE_SHIFT;
    n3_nxt.c[1].t = cst_pkg::T_W'(a2_r) << cst_pkg::ONE_SHIFT;
    n3_nxt.c[2].t = cst_pkg::T_W'(b2_r) << cst_pkg::ONE_SHIFT;
    for (int i = 0; i < 3; i++) begin
      n3_nxt.c[i].m = '0;
      n3_nxt.c[i].e = $signed({{(cst_pkg::E_W-cst_pkg::S_W){1'b0}}, s_sum});
      n3_nxt.c[i].p = -$signed({{(cst_pkg::P_W-cst_pkg::S_W){1'b0}}, s_sum});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n3_r.side.valid <= 1'b0;
    end else if (adv) begin
      n3_r <= n3_nxt;
    end
  end

  assign norm_o = n3_r;

endmodule

### hdl/cst_norm_stage.sv
// ----------------------------------------------------------------------------
// cst_norm_stage
// One bit of the rounded unit-length search, for all three components.
// ----------------------------------------------------------------------------
module cst_norm_stage #(
  parameter int K = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  cst_pkg::norm_t d_i,
  output cst_pkg::norm_t q_o
);

  cst_pkg::norm_t                q_r, q_nxt;
  logic signed [cst_pkg::E_W-1:0] s_ext, p_ext, e_try, p_try;
  logic signed [cst_pkg::E_W-1:0] t_ext;

  always_comb begin
    q_nxt = d_i;
    s_ext = $signed({{(cst_pkg::E_W-cst_pkg::S_W){1'b0}}, d_i.side.s});
    for (int i = 0; i < 3; i++) begin
      p_ext = cst_pkg::E_W'(d_i.c[i].p);
      t_ext = $signed({{(cst_pkg::E_W-cst_pkg::T_W){1'b0}}, d_i.c[i].t});
      // (2m-1)^2 s grown by the trial bit
      e_try = d_i.c[i].e + (p_ext <<< (K + 2)) + (s_ext <<< (2 * K + 2));
      p_try = p_ext + (s_ext <<< (K + 1));
      if (e_try <= t_ext) begin
        q_nxt.c[i].m = d_i.c[i].m | cst_pkg::MAG_W'(1 << K);
        q_nxt.c[i].e = e_try;
        q_nxt.c[i].p = p_try[cst_pkg::P_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.side.valid <= 1'b0;
    end else if (adv) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

### hdl/cst_out.sv
// ----------------------------------------------------------------------------
// cst_out
// Face mapping, output register and six-word quad sequencer.
// ----------------------------------------------------------------------------
module cst_out (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cst_pkg::norm_t                   d_i,
  output logic                             adv,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [cst_pkg::POS_W-1:0] out_pos_x,
  output logic signed [cst_pkg::POS_W-1:0] out_pos_y,
  output logic signed [cst_pkg::POS_W-1:0] out_pos_z,
  output logic [cst_pkg::IDX_W-1:0]        out_vertex_index,
  output logic                             out_last
);

  logic                              ov_r;
  cst_pkg::op_t                      op_r;
  cst_pkg::beat_t                    beat_r;
  logic signed [cst_pkg::POS_W-1:0]  x_r, y_r, z_r;
  logic signed [cst_pkg::POS_W-1:0]  px, py, pz, ox, oy, oz;
  logic [cst_pkg::IDX_W-1:0]         lt_r;
  logic [8:0]                        n_r;
  logic [cst_pkg::IDX_W-1:0]         n_ext;

  always_comb begin
    px = $signed({1'b0, d_i.c[0].m});
    py = d_i.side.neg_a ? -$signed({1'b0, d_i.c[1].m}) : $signed({1'b0, d_i.c[1].m});
    pz = d_i.side.neg_b ? -$signed({1'b0, d_i.c[2].m}) : $signed({1'b0, d_i.c[2].m});
    case (d_i.side.face)
      3'd0: begin ox = -px; oy = py;  oz = pz;  end
      3'd1: begin ox = px;  oy = -py; oz = pz;  end
      3'd2: begin ox = py;  oy = px;  oz = pz;  end
      3'd3: begin ox = -py; oy = -px; oz = pz;  end
      3'd4: begin ox = pz;  oy = py;  oz = px;  end
      default: begin ox = pz; oy = -py; oz = -px; end
    endcase
  end

  assign out_last  = (op_r == cst_pkg::OP_QUAD) ? (beat_r == cst_pkg::BEAT_LB2) : 1'b1;
  assign out_valid = ov_r;
  assign adv       = !ov_r || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      beat_r <= cst_pkg::BEAT_LT;
    end else if (adv) begin
      ov_r   <= d_i.side.valid;
      beat_r <= cst_pkg::BEAT_LT;
    end else if (out_ready) begin
      beat_r <= cst_pkg::beat_t'(beat_r + 3'd1);
    end
    if (adv) begin
      op_r <= d_i.side.op;
      x_r  <= ox;
      y_r  <= oy;
      z_r  <= oz;
      lt_r <= d_i.side.lt;
      n_r  <= d_i.side.n;
    end
  end

  always_comb begin
    n_ext = cst_pkg::IDX_W'(n_r);
    case (beat_r)
      cst_pkg::BEAT_LT:  out_vertex_index = lt_r;
      cst_pkg::BEAT_LB:  out_vertex_index = lt_r + n_ext;
      cst_pkg::BEAT_RT:  out_vertex_index = lt_r + 19'd1;
      cst_pkg::BEAT_RB:  out_vertex_index = lt_r + n_ext + 19'd1;
      cst_pkg::BEAT_RT2: out_vertex_index = lt_r + 19'd1;
      default:           out_vertex_index = lt_r + n_ext;
    endcase
  end

  assign out_pos_x = (op_r == cst_pkg::OP_QUAD) ? '0 : x_r;
  assign out_pos_y = (op_r == cst_pkg::OP_QUAD) ? '0 : y_r;
  assign out_pos_z = (op_r == cst_pkg::OP_QUAD) ? '0 : z_r;

endmodule

### hdl/cube_sphere_tessellator_top.sv
// ----------------------------------------------------------------------------
// cube_sphere_tessellator_top
// Cube-sphere vertex positions and quad indices, fully pipelined.
//
//   channel  | handshake            | payload
//   in       | in_valid / in_ready  | in_op, in_face, in_row, in_column
//   out      | out_valid / out_ready| out_pos_x/y/z, out_vertex_index, out_last
//   cfg      | cfg_we               | cfg_wdata (detail level)
//
// from accept to first word a request passes three set-up stages, fifteen
// search stages (one magnitude bit each) and the output register.
// one vertex request per cycle while out_ready is high; a quad request holds the output for six words.
// a stall at the output freezes every stage together; nothing is lost.
// synchronous active-low reset clears valid bits and the detail level.
// ----------------------------------------------------------------------------
module cube_sphere_tessellator_top #(
  parameter int MAX_VERTS_PER_EDGE = cst_pkg::MAX_VERTS_PER_EDGE
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [2:0]                       in_face,
  input  logic [7:0]                       in_row,
  input  logic [7:0]                       in_column,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [cst_pkg::POS_W-1:0] out_pos_x,
  output logic signed [cst_pkg::POS_W-1:0] out_pos_y,
  output logic signed [cst_pkg::POS_W-1:0] out_pos_z,
  output logic [cst_pkg::IDX_W-1:0]        out_vertex_index,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [7:0]                       cfg_wdata
);

  localparam int NSTEP = cst_pkg::MAG_W;

  logic           adv;
  logic [7:0]     detail_r;
  cst_pkg::norm_t chain [NSTEP+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detail_r <= 8'd0;
    end else if (cfg_we) begin
      detail_r <= cfg_wdata;
    end
  end

  assign in_ready = adv;

  cst_front #(.MAX_VERTS_PER_EDGE(MAX_VERTS_PER_EDGE)) u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .detail(detail_r),
    .in_valid(in_valid), .in_op(in_op), .in_face(in_face),
    .in_row(in_row), .in_column(in_column), .norm_o(chain[0])
  );

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    cst_norm_stage #(.K(NSTEP - 1 - g)) u_step (
      .clk(clk), .rst_n(rst_n), .adv(adv), .d_i(chain[g]), .q_o(chain[g+1])
    );
  end

  cst_out u_out (
    .clk(clk), .rst_n(rst_n), .d_i(chain[NSTEP]), .adv(adv),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_vertex_index(out_vertex_index), .out_last(out_last)
  );

endmodule

### hdl/cst_checker.sv
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks on the tessellator, bound to the top level.
// ----------------------------------------------------------------------------
module cst_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [cst_pkg::POS_W-1:0] out_pos_x,
  input logic signed [cst_pkg::POS_W-1:0] out_pos_y,
  input logic signed [cst_pkg::POS_W-1:0] out_pos_z,
  input logic [cst_pkg::IDX_W-1:0]        out_vertex_index,
  input logic                             out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex_index))
    else $error("output word changed while stalled");

  a_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_pos_x == 0 && out_pos_y == 0 && out_pos_z == 0)
    else $error("index word carries a position");

  a_quad_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("quad words interrupted");

  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pos_x <= 16384 && out_pos_x >= -16384 &&
                  out_pos_y <= 16384 && out_pos_y >= -16384)
    else $error("position outside unit range");

endmodule

bind cube_sphere_tessellator_top cst_checker u_cst_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
  .out_vertex_index(out_vertex_index), .out_last(out_last)
);

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cube-sphere tessellator: a directed table of
// vertex and quad requests, then random requests over several detail levels,
// with every output word compared against an in-bench predictor.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LAT      = 19;
  localparam int LIMIT    = 400000;
  localparam int N_RANDOM = 190;

  typedef struct {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic [18:0]        vidx;
    logic               last;
  } word_t;

  typedef struct {
    cst_pkg::op_t op;
    logic [2:0]   face;
    logic [7:0]   row;
    logic [7:0]   col;
    bit           typed;
    logic [18:0]  vidx0;
  } stim_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_op = 0;
  logic [2:0]  in_face = 0;
  logic [7:0]  in_row = 0;
  logic [7:0]  in_column = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic signed [15:0] out_pos_x, out_pos_y, out_pos_z;
  logic [18:0] out_vertex_index;
  logic        out_last;
  logic        cfg_we = 0;
  logic [7:0]  cfg_wdata = 0;

  word_t expected_words[$];
  logic [7:0] detail;
  int  errors = 0;
  int  cycles = 0;
  bit  sink_idle = 1;
  bit  hold_sink = 0;
  bit  no_gaps = 0;

  cube_sphere_tessellator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_face(in_face),
    .in_row(in_row), .in_column(in_column),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_vertex_index(out_vertex_index), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // round(x * 16384 / sqrt(s)), ties away from zero
  function automatic logic signed [15:0] unit_comp(int x, longint s);
    longint ax, t, t4, d;
    int lo, hi, mid;
    ax = (x < 0) ? -x : x;
    t = ax * 16384;
    t4 = 4 * t * t;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d = 2 * mid - 1;
      if (d * d * s <= t4) lo = mid;
      else hi = mid - 1;
    end
    return (x < 0) ? -lo : lo;
  endfunction

  task automatic predict_words(cst_pkg::op_t op, logic [2:0] face_in, logic [7:0] row_in,
                               logic [7:0] col_in);
    int q, n, f, r, c, a, b, base, lt;
    longint s;
    logic signed [15:0] ux, uy, uz;
    word_t w;
    int idx[6];
    q = detail + 1;
    if (q > cst_pkg::MAX_VERTS_PER_EDGE - 1) q = cst_pkg::MAX_VERTS_PER_EDGE - 1;
    n = q + 1;
    f = (face_in > cst_pkg::FACE_LAST) ? cst_pkg::FACE_LAST : face_in;
    base = f * n * n;
    r = row_in;
    c = col_in;
    if (op == cst_pkg::OP_VERTEX) begin
      if (r > q) r = q;
      if (c > q) c = q;
      a = 2 * c - q;
      b = 2 * r - q;
      s = longint'(q) * q + longint'(a) * a + longint'(b) * b;
      ux = unit_comp(q, s);
      uy = unit_comp(a, s);
      uz = unit_comp(b, s);
      case (f)
        0: begin w.px = -ux; w.py = uy;  w.pz = uz;  end
        1: begin w.px = ux;  w.py = -uy; w.pz = uz;  end
        2: begin w.px = uy;  w.py = ux;  w.pz = uz;  end
        3: begin w.px = -uy; w.py = -ux; w.pz = uz;  end
        4: begin w.px = uz;  w.py = uy;  w.pz = ux;  end
        default: begin w.px = uz; w.py = -uy; w.pz = -ux; end
      endcase
      w.vidx = base + r * n + c;
      w.last = 1;
      expected_words.push_back(w);
    end else begin
      if (r > q - 1) r = q - 1;
      if (c > q - 1) c = q - 1;
      lt = base + r * n + c;
      idx = '{lt, lt + n, lt + 1, lt + n + 1, lt + 1, lt + n};
      for (int k = 0; k < 6; k++) begin
        w.px = 0;
        w.py = 0;
        w.pz = 0;
        w.vidx = idx[k];
        w.last = (k == 5);
        expected_words.push_back(w);
      end
    end
  endtask

  task automatic send_word(cst_pkg::op_t op, logic [2:0] f, logic [7:0] r, logic [7:0] c);
    in_valid <= 1;
    in_op <= op;
    in_face <= f;
    in_row <= r;
    in_column <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_words(op, f, r, c);
    @(negedge clk);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (LAT + 4) @(negedge clk);
  endtask

  task automatic write_detail(logic [7:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    detail = v;
  endtask

  // receiver stalls
  always @(negedge clk) begin
    if (hold_sink || (!no_gaps && !sink_idle && $urandom_range(0, 4) == 0)) begin
      out_ready <= 0;
      if (!hold_sink) begin
        sink_idle = 1;
        fork
          begin
            repeat ($urandom_range(1, 13)) @(negedge clk);
            sink_idle = 0;
          end
        join_none
      end
    end else if (!sink_idle || no_gaps) begin
      out_ready <= 1;
    end
  end

  // output checker
  always @(posedge clk) begin
    word_t e;
    cycles++;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: idx %0d", out_vertex_index);
      end else begin
        e = expected_words.pop_front();
        if (e.px !== out_pos_x || e.py !== out_pos_y || e.pz !== out_pos_z ||
            e.vidx !== out_vertex_index || e.last !== out_last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                     e.px, e.py, e.pz, e.vidx, e.last, out_pos_x, out_pos_y,
                     out_pos_z, out_vertex_index, out_last);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  stim_t dir_table[] = '{
    '{cst_pkg::OP_VERTEX, 3'd0, 8'd0,   8'd0,   1, 19'd0},
    '{cst_pkg::OP_VERTEX, 3'd0, 8'd1,   8'd1,   1, 19'd3},
    '{cst_pkg::OP_VERTEX, 3'd5, 8'd0,   8'd1,   1, 19'd21},
    '{cst_pkg::OP_QUAD,   3'd0, 8'd0,   8'd0,   1, 19'd0},
    '{cst_pkg::OP_QUAD,   3'd3, 8'd255, 8'd255, 1, 19'd12},
    '{cst_pkg::OP_VERTEX, 3'd7, 8'd255, 8'd255, 1, 19'd23},
    '{cst_pkg::OP_QUAD,   3'd6, 8'd0,   8'd0,   1, 19'd20},
    '{cst_pkg::OP_VERTEX, 3'd1, 8'd0,   8'd1,   0, 19'd0},
    '{cst_pkg::OP_VERTEX, 3'd2, 8'd1,   8'd0,   0, 19'd0},
    '{cst_pkg::OP_VERTEX, 3'd3, 8'd1,   8'd0,   0, 19'd0},
    '{cst_pkg::OP_VERTEX, 3'd4, 8'd0,   8'd1,   0, 19'd0}
  };

  initial begin
    int sel;
    int back;
    logic [7:0] levels[5];
    detail = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1;
    sink_idle = 0;
    @(negedge clk);
    // detail 0 after reset: 2x2 vertices per face
    foreach (dir_table[i]) begin
      send_word(dir_table[i].op, dir_table[i].face, dir_table[i].row, dir_table[i].col);
      // first word of the request
      back = (dir_table[i].op == cst_pkg::OP_QUAD) ? 5 : 0;
      if (dir_table[i].typed && expected_words[$ - back].vidx !== dir_table[i].vidx0) begin
        errors++;
        if (errors <= 10)
          $display("table row %0d: exp index %0d got %0d", i, dir_table[i].vidx0,
                   expected_words[$ - back].vidx);
      end
    end
    drain();
    write_detail(8'd254);
    send_word(cst_pkg::OP_VERTEX, 3'd5, 8'd255, 8'd255);
    send_word(cst_pkg::OP_QUAD, 3'd5, 8'd255, 8'd255);
    send_word(cst_pkg::OP_VERTEX, 3'd4, 8'd127, 8'd0);
    send_word(cst_pkg::OP_VERTEX, 3'd2, 8'd170, 8'd85);
    drain();

    // long receiver hold-off while the sender keeps going
    hold_sink = 1;
    fork
      begin
        repeat (150) @(negedge clk);
        hold_sink = 0;
      end
    join_none
    for (int k = 0; k < 20; k++)
      send_word(cst_pkg::OP_VERTEX, $urandom_range(0, 7), $urandom, $urandom);
    drain();

    levels = '{8'd1, 8'd255, 8'd7, 8'($urandom), 8'd3};
    for (int p = 0; p < 5; p++) begin
      write_detail(levels[p]);
      if (p == 4) no_gaps = 1;
      for (int k = 0; k < N_RANDOM / 5; k++) begin
        sel = $urandom_range(0, 9);
        if (sel < 6)
          send_word(cst_pkg::OP_VERTEX, $urandom_range(0, 5), $urandom_range(0, detail + 1),
                    $urandom_range(0, detail + 1));
        else if (sel < 8)
          send_word(cst_pkg::OP_QUAD, $urandom_range(0, 5), $urandom_range(0, detail),
                    $urandom_range(0, detail));
        else
          send_word(cst_pkg::op_t'($urandom_range(0, 1)), $urandom_range(0, 7),
                    $urandom, $urandom);
      end
      drain();
    end

    if (errors == 0 && expected_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/cst_pkg.sv
hdl/cst_front.sv
hdl/cst_norm_stage.sv
hdl/cst_out.sv
hdl/cube_sphere_tessellator_top.sv
hdl/cst_checker.sv
tb/sv/testbench.sv
